>>> hw/rtl/asd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Request queue between the frame parser and the table engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 136;

  // Frame layout, in byte positions from the start of the frame.
  localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
  localparam logic [POS_W-1:0] ETHTYPE_POS   = 6'd12;
  localparam logic [POS_W-1:0] OPCODE_POS    = 6'd20;
  localparam logic [POS_W-1:0] MAC_POS       = 6'd22;
  localparam logic [POS_W-1:0] MAC_ADDR_LEN  = 6'd6;
  localparam logic [POS_W-1:0] IP_POS        = 6'd28;
  localparam logic [POS_W-1:0] IP_ADDR_LEN   = 6'd4;
  // The final byte of a long enough frame sits at this position or later.
  localparam logic [POS_W-1:0] MIN_LAST_POS  = 6'd31;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] OPCODE_REPLY  = 16'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_NOT_REPLY  = 3'd0;
  localparam logic [STAT_W-1:0] ST_LEARNED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_CONSISTENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_SPOOF      = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  // One finished frame, handed from the parser to the table engine.
  typedef struct packed {
    logic             is_reply;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  // One table entry.
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> hw/rtl/asd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/asd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        byte_valid_i,
  input  wire logic [asd_pkg::BYTE_W-1:0]  byte_i,
  input  wire logic                        last_i,
  input  wire logic                        queue_full_i,
  output logic                             byte_ready_o,
  output logic                             push_o,
  output asd_pkg::req_t                    req_o
);

  logic [asd_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [15:0]                eth_q, eth_d;
  logic [15:0]                op_q, op_d;
  logic [asd_pkg::MAC_W-1:0]  mac_q, mac_d;
  logic [asd_pkg::IP_W-1:0]   ip_q, ip_d;
  logic                       take;

  assign byte_ready_o = !queue_full_i;
  assign take         = byte_valid_i && byte_ready_o;

  // Capture header fields as their bytes go by.
  always_comb begin
    eth_d = eth_q;
    op_d  = op_q;
    mac_d = mac_q;
    ip_d  = ip_q;
    if (pos_q == asd_pkg::ETHTYPE_POS || pos_q == asd_pkg::ETHTYPE_POS + 6'd1) begin
      eth_d = {eth_q[7:0], byte_i};
    end else if (pos_q == asd_pkg::OPCODE_POS ||
                 pos_q == asd_pkg::OPCODE_POS + 6'd1) begin
      op_d = {op_q[7:0], byte_i};
    end else if (pos_q >= asd_pkg::MAC_POS &&
                 pos_q < asd_pkg::MAC_POS + asd_pkg::MAC_ADDR_LEN) begin
      mac_d = {mac_q[asd_pkg::MAC_W-9:0], byte_i};
    end else if (pos_q >= asd_pkg::IP_POS &&
                 pos_q < asd_pkg::IP_POS + asd_pkg::IP_ADDR_LEN) begin
      ip_d = {ip_q[asd_pkg::IP_W-9:0], byte_i};
    end
    pos_d = (pos_q < asd_pkg::POS_MAX) ? pos_q + 6'd1 : pos_q;
  end

  // A request goes to the queue on the final byte of each frame.
  assign push_o           = take && last_i;
  assign req_o.is_reply   = (pos_q >= asd_pkg::MIN_LAST_POS) &&
                            (eth_d == asd_pkg::ETHERTYPE_ARP) &&
                            (op_d == asd_pkg::OPCODE_REPLY);
  assign req_o.ip         = ip_d;
  assign req_o.mac        = mac_d;

  // Frame state; cleared after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      eth_q <= '0;
      op_q  <= '0;
      mac_q <= '0;
      ip_q  <= '0;
    end else if (take) begin
      if (last_i) begin
        pos_q <= '0;
        eth_q <= '0;
        op_q  <= '0;
        mac_q <= '0;
        ip_q  <= '0;
      end else begin
        pos_q <= pos_d;
        eth_q <= eth_d;
        op_q  <= op_d;
        mac_q <= mac_d;
        ip_q  <= ip_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/asd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire asd_pkg::req_t push_data_i,
  input  wire logic          pop_i,
  output asd_pkg::req_t      pop_data_o,
  output logic               empty_o,
  output logic               full_o
);

  asd_pkg::req_t                 slot_q [asd_pkg::QUEUE_DEPTH];
  logic [asd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [asd_pkg::QCNT_W-1:0]    count_q;
  logic                          do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == asd_pkg::QCNT_W'(asd_pkg::QUEUE_DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == asd_pkg::QPTR_W'(asd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + asd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == asd_pkg::QPTR_W'(asd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + asd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + asd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - asd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/asd_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

module asd_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          queue_empty_i,
  input  wire asd_pkg::req_t                 queue_data_i,
  output logic                               pop_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [asd_pkg::STAT_W-1:0]         res_status_o,
  output logic [asd_pkg::IP_W-1:0]           res_ip_o,
  output logic [asd_pkg::MAC_W-1:0]          res_rx_mac_o,
  output logic [asd_pkg::MAC_W-1:0]          res_cached_mac_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                        state_q, state_d;
  asd_pkg::req_t                 req_q, req_d;
  logic [asd_pkg::CNT_W-1:0]     fill_q, fill_d;
  logic [asd_pkg::CNT_W-1:0]     issue_q, issue_d, issue_inc;
  logic                          cmp_vld_q, cmp_vld_d;
  logic                          cmp_last_q, cmp_last_d;
  logic                          out_vld_q, out_vld_d;
  logic [asd_pkg::STAT_W-1:0]    out_status_q, out_status_d;
  logic [asd_pkg::IP_W-1:0]      out_ip_q, out_ip_d;
  logic [asd_pkg::MAC_W-1:0]     out_rx_q, out_rx_d;
  logic [asd_pkg::MAC_W-1:0]     out_cached_q, out_cached_d;

  logic                          ram_we, ram_re;
  logic [asd_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  asd_pkg::entry_t               ram_wdata, ram_rdata;

  // Entries are filled in order, so the fill count stands in for valid bits.
  asd_ram #(
    .WIDTH(asd_pkg::ENTRY_W),
    .DEPTH(asd_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign issue_inc     = issue_q + asd_pkg::CNT_W'(1);
  assign ram_raddr     = issue_q[asd_pkg::IDX_W-1:0];
  assign ram_waddr     = fill_q[asd_pkg::IDX_W-1:0];
  assign ram_wdata.ip  = req_q.ip;
  assign ram_wdata.mac = req_q.mac;

  // Request handling and table scan: one read issued per cycle, each compared in the cycle after its issue.
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    fill_d       = fill_q;
    issue_d      = issue_q;
    cmp_vld_d    = 1'b0;
    cmp_last_d   = cmp_last_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_ip_d     = out_ip_q;
    out_rx_d     = out_rx_q;
    out_cached_d = out_cached_q;
    pop_o        = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;

    if (out_vld_q && res_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!queue_empty_i && !out_vld_q) begin
          pop_o = 1'b1;
          req_d = queue_data_i;
          if (!queue_data_i.is_reply) begin
            out_vld_d    = 1'b1;
            out_status_d = asd_pkg::ST_NOT_REPLY;
            out_ip_d     = '0;
            out_rx_d     = '0;
            out_cached_d = '0;
          end else begin
            issue_d = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_q < fill_q) begin
          ram_re     = 1'b1;
          issue_d    = issue_inc;
          cmp_vld_d  = 1'b1;
          cmp_last_d = (issue_inc == fill_q);
        end
        if (cmp_vld_q && ram_rdata.ip == req_q.ip) begin
          // Known address: compare the stored MAC.
          cmp_vld_d    = 1'b0;
          state_d      = S_IDLE;
          out_vld_d    = 1'b1;
          out_status_d = (ram_rdata.mac == req_q.mac) ?
                         asd_pkg::ST_CONSISTENT : asd_pkg::ST_SPOOF;
          out_ip_d     = req_q.ip;
          out_rx_d     = req_q.mac;
          out_cached_d = ram_rdata.mac;
        end else if ((cmp_vld_q && cmp_last_q) || fill_q == '0) begin
          // Unknown address: learn it if there is room.
          cmp_vld_d    = 1'b0;
          state_d      = S_IDLE;
          out_vld_d    = 1'b1;
          out_ip_d     = req_q.ip;
          out_rx_d     = req_q.mac;
          out_cached_d = '0;
          if (fill_q < asd_pkg::CNT_W'(asd_pkg::TABLE_ENTRIES)) begin
            ram_we       = 1'b1;
            fill_d       = fill_q + asd_pkg::CNT_W'(1);
            out_status_d = asd_pkg::ST_LEARNED;
          end else begin
            out_status_d = asd_pkg::ST_FULL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, request and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      issue_q      <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      req_q        <= '0;
      out_status_q <= '0;
      out_ip_q     <= '0;
      out_rx_q     <= '0;
      out_cached_q <= '0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      issue_q      <= issue_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_last_q   <= cmp_last_d;
      out_vld_q    <= out_vld_d;
      req_q        <= req_d;
      out_status_q <= out_status_d;
      out_ip_q     <= out_ip_d;
      out_rx_q     <= out_rx_d;
      out_cached_q <= out_cached_d;
    end
  end

  assign res_valid_o      = out_vld_q;
  assign res_status_o     = out_status_q;
  assign res_ip_o         = out_ip_q;
  assign res_rx_mac_o     = out_rx_q;
  assign res_cached_mac_o = out_cached_q;

endmodule

`default_nettype wire

>>> hw/rtl/arp_spoof_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// ARP spoof detector. Frame bytes stream in on the slave side one per
// transfer, with tlast on the final byte, and are taken every cycle while the
// request queue has room. Each final byte yields one result transfer. A frame
// that is not an ARP reply of at least 32 bytes gives status 0 through the
// request queue and the result register. A reply looks its sender IP up in a
// table of TABLE_ENTRIES entries held in a RAM that a sequential engine scans
// one entry per cycle from entry 0, so a new IP gives its result after all
// filled entries are read, and a stored IP gives it once its entry matches;
// the scan length sets the time per frame. A result is delayed while the
// engine is busy or the master side is not ready. A four-deep request queue
// lets the parser keep taking bytes while the engine works, and the result
// register holds a finished result until the master side takes it. The table
// is empty after reset.

module arp_spoof_detector (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic          s_axis_tlast_i,   // last_byte
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [135:0]       m_axis_tdata_o    // [2:0] status, [34:3] sender_ip,
                                               // [82:35] received_mac,
                                               // [130:83] cached_mac, rest zero
);

  logic                              push, pop, q_empty, q_full;
  asd_pkg::req_t                     push_req, pop_req;
  logic [asd_pkg::STAT_W-1:0]        res_status;
  logic [asd_pkg::IP_W-1:0]          res_ip;
  logic [asd_pkg::MAC_W-1:0]         res_rx, res_cached;

  // Front: byte parsing and classification.
  asd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid_i),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .queue_full_i(q_full),
    .byte_ready_o(s_axis_tready_o),
    .push_o      (push),
    .req_o       (push_req)
  );

  // Request queue between parser and table engine.
  asd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_req),
    .pop_i      (pop),
    .pop_data_o (pop_req),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Back: table lookup, learning and result register.
  asd_lookup u_lookup (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .queue_empty_i   (q_empty),
    .queue_data_i    (pop_req),
    .pop_o           (pop),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_status_o    (res_status),
    .res_ip_o        (res_ip),
    .res_rx_mac_o    (res_rx),
    .res_cached_mac_o(res_cached)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_axis_tdata_o = {5'd0, res_cached, res_rx, res_ip, res_status};

endmodule

`default_nettype wire
